### rtl/core/assert_macros.svh
// Shared assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clock and reset names.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/dofu_pkg.sv
`default_nettype none
package dofu_pkg;

  localparam int COORD_BITS     = 24;
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int SUM_BITS       = 2 * DIFF_BITS;
  localparam int ROOT_BITS      = SUM_BITS / 2;
  localparam int REM_BITS       = ROOT_BITS + 3;
  localparam int DIST_BITS      = 24;
  localparam int CMP_BITS       = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;
  localparam int OPA_FRAC_BITS  = 16;
  localparam int OPA_BITS       = OPA_FRAC_BITS + 1;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [OPA_BITS-1:0] ONE = {1'b1, {OPA_FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NEAR_TRANSP = 2'd0,
    REG_NEAR_OPAQUE = 2'd1,
    REG_FAR_OPAQUE  = 2'd2,
    REG_FAR_TRANSP  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_NEAR,
    SEL_FAR
  } sel_e;

  typedef struct packed {
    sel_e                 sel;
    logic [DIST_BITS-1:0] num;
    logic [DIST_BITS-1:0] den;
  } ramp_t;

  typedef struct packed {
    sel_e                sel;
    logic [OPA_BITS-1:0] quot;
  } div_res_t;

  function automatic logic [DIFF_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

endpackage
`default_nettype wire

### rtl/core/dofu_if.sv
`default_nettype none
interface dofu_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dofu_pkg::COORD_BITS-1:0]  target_x;
  logic signed [dofu_pkg::COORD_BITS-1:0]  target_y;
  logic signed [dofu_pkg::COORD_BITS-1:0]  target_z;
  logic signed [dofu_pkg::COORD_BITS-1:0]  ref_x;
  logic signed [dofu_pkg::COORD_BITS-1:0]  ref_y;
  logic signed [dofu_pkg::COORD_BITS-1:0]  ref_z;

  modport source (output valid, target_x, target_y, target_z, ref_x, ref_y, ref_z,
                  input ready);
  modport sink (input valid, target_x, target_y, target_z, ref_x, ref_y, ref_z,
                output ready);
endinterface

interface dofu_out_if;
  logic                            valid;
  logic                            ready;
  logic [dofu_pkg::OPA_BITS-1:0]   opacity;

  modport source (output valid, opacity, input ready);
  modport sink (input valid, opacity, output ready);
endinterface
`default_nettype wire

### rtl/core/dofu_sqdist.sv
`default_nettype none
module dofu_sqdist (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] target_x_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] target_y_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] target_z_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] ref_x_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] ref_y_i,
  input  wire logic signed [dofu_pkg::COORD_BITS-1:0] ref_z_i,
  output logic                                        valid_o,
  output logic [dofu_pkg::SUM_BITS-1:0]               sum_o
);

  logic [2:0]                          v_q;
  logic [dofu_pkg::DIFF_BITS-1:0]      dx_q, dy_q, dz_q;
  logic [dofu_pkg::SUM_BITS-1:0]       sx_q, sy_q, sz_q;
  logic [dofu_pkg::SUM_BITS-1:0]       sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dofu_pkg::abs_diff(target_x_i, ref_x_i);
      dy_q  <= dofu_pkg::abs_diff(target_y_i, ref_y_i);
      dz_q  <= dofu_pkg::abs_diff(target_z_i, ref_z_i);
      sx_q  <= dofu_pkg::SUM_BITS'(dx_q) * dofu_pkg::SUM_BITS'(dx_q);
      sy_q  <= dofu_pkg::SUM_BITS'(dy_q) * dofu_pkg::SUM_BITS'(dy_q);
      sz_q  <= dofu_pkg::SUM_BITS'(dz_q) * dofu_pkg::SUM_BITS'(dz_q);
      sum_q <= sx_q + sy_q + sz_q;
    end
  end

  assign valid_o = v_q[2];
  assign sum_o   = sum_q;

endmodule
`default_nettype wire

### rtl/core/dofu_isqrt.sv
`default_nettype none
module dofu_isqrt (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic                                 valid_i,
  input  wire logic [dofu_pkg::SUM_BITS-1:0]        x_i,
  output logic                                      valid_o,
  output logic [dofu_pkg::ROOT_BITS-1:0]            root_o
);

  localparam int N = dofu_pkg::ROOT_BITS;

  logic                                 v_q    [N];
  logic [dofu_pkg::SUM_BITS-1:0]        x_q    [N];
  logic [dofu_pkg::REM_BITS-1:0]        rem_q  [N];
  logic [dofu_pkg::ROOT_BITS-1:0]       root_q [N];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                             v_in;
    logic [dofu_pkg::SUM_BITS-1:0]    x_in;
    logic [dofu_pkg::REM_BITS-1:0]    rem_in, rem_sh, trial;
    logic [dofu_pkg::ROOT_BITS-1:0]   root_in;
    logic                             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[dofu_pkg::REM_BITS-3:0], x_in[dofu_pkg::SUM_BITS-1-2*k -: 2]};
      trial  = dofu_pkg::REM_BITS'({root_in, 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in;
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[dofu_pkg::ROOT_BITS-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];

endmodule
`default_nettype wire

### rtl/core/dofu_div.sv
`default_nettype none
module dofu_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire dofu_pkg::ramp_t     ramp_i,
  output logic                     valid_o,
  output dofu_pkg::div_res_t       res_o
);

  localparam int N  = dofu_pkg::OPA_FRAC_BITS + 1;
  localparam int DW = dofu_pkg::DIST_BITS;
  localparam int QW = dofu_pkg::OPA_BITS;

  logic                 v_q    [N];
  dofu_pkg::sel_e       sel_q  [N];
  logic [DW-1:0]        den_q  [N];
  logic [DW-1:0]        rem_q  [N];
  logic [QW-1:0]        quot_q [N];

  // Stage 0 settles the integer bit, the rest one fraction bit each.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              v_in;
    dofu_pkg::sel_e    sel_in;
    logic [DW-1:0]     den_in;
    logic [DW:0]       rem_sh;
    logic [QW-1:0]     quot_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign sel_in  = ramp_i.sel;
      assign den_in  = ramp_i.den;
      assign rem_sh  = {1'b0, ramp_i.num};
      assign quot_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign sel_in  = sel_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_sh  = {rem_q[k-1], 1'b0};
      assign quot_in = quot_q[k-1];
    end

    assign ge = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sel_q[k]  <= sel_in;
        den_q[k]  <= den_in;
        rem_q[k]  <= ge ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
        quot_q[k] <= {quot_in[QW-2:0], ge};
      end
    end
  end

  assign valid_o    = v_q[N-1];
  assign res_o.sel  = sel_q[N-1];
  assign res_o.quot = quot_q[N-1];

endmodule
`default_nettype wire

### rtl/core/distance_opacity_fade_unit.sv
// Pipeline from an accepted word to its result word at the output: 3 distance stages,
// 25 square root stages, 1 classify stage, 17 divider stages and 1 output register.
// Throughput: one word per cycle; while a result waits, the skid word takes the next
// result and then the input stalls until the output drains.
// Reset: asynchronous, active low; clears all valid bits and the four
// distance registers to zero.
`default_nettype none
`include "assert_macros.svh"
module distance_opacity_fade_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dofu_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [dofu_pkg::DIST_BITS-1:0]        cfg_wdata_i,
  dofu_in_if.sink                                    in_i,
  dofu_out_if.source                                 out_o
);

  localparam int CW = dofu_pkg::CMP_BITS;
  localparam int DW = dofu_pkg::DIST_BITS;

  logic [DW-1:0] near_t_q, near_o_q, far_o_q, far_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_t_q <= '0;
      near_o_q <= '0;
      far_o_q  <= '0;
      far_t_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (dofu_pkg::cfg_reg_e'(cfg_idx_i))
        dofu_pkg::REG_NEAR_TRANSP: near_t_q <= cfg_wdata_i;
        dofu_pkg::REG_NEAR_OPAQUE: near_o_q <= cfg_wdata_i;
        dofu_pkg::REG_FAR_OPAQUE:  far_o_q  <= cfg_wdata_i;
        dofu_pkg::REG_FAR_TRANSP:  far_t_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid word is occupied.
  logic en;
  logic skid_v_q, out_v_q;
  logic [dofu_pkg::OPA_BITS-1:0] skid_d_q, out_d_q;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  logic                              sq_v;
  logic [dofu_pkg::SUM_BITS-1:0]     sq_sum;
  logic                              rt_v;
  logic [dofu_pkg::ROOT_BITS-1:0]    rt_root;

  dofu_sqdist u_sqdist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_i.valid),
    .target_x_i (in_i.target_x),
    .target_y_i (in_i.target_y),
    .target_z_i (in_i.target_z),
    .ref_x_i    (in_i.ref_x),
    .ref_y_i    (in_i.ref_y),
    .ref_z_i    (in_i.ref_z),
    .valid_o    (sq_v),
    .sum_o      (sq_sum)
  );

  dofu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .x_i     (sq_sum),
    .valid_o (rt_v),
    .root_o  (rt_root)
  );

  // Classify the distance against the trapezoid and set up the ramp division.
  logic [CW-1:0]     d, nt, no, fo, ft;
  dofu_pkg::ramp_t   cls_d, cls_q;
  logic              cls_v_q;

  always_comb begin
    d  = CW'(rt_root);
    nt = CW'(near_t_q);
    no = CW'(near_o_q);
    fo = CW'(far_o_q);
    ft = CW'(far_t_q);
    cls_d.sel = dofu_pkg::SEL_ONE;
    cls_d.num = '0;
    cls_d.den = '0;
    if (d > ft || d < nt) begin
      cls_d.sel = dofu_pkg::SEL_ZERO;
    end else if (d > fo) begin
      cls_d.sel = dofu_pkg::SEL_FAR;
      cls_d.num = DW'(d - fo);
      cls_d.den = DW'(ft - fo);
    end else if (d < no) begin
      cls_d.sel = dofu_pkg::SEL_NEAR;
      cls_d.num = DW'(d - nt);
      cls_d.den = DW'(no - nt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_v_q <= 1'b0;
    end else if (en) begin
      cls_v_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q <= cls_d;
    end
  end

  logic                  dv_v;
  dofu_pkg::div_res_t    dv_res;

  dofu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cls_v_q),
    .ramp_i  (cls_q),
    .valid_o (dv_v),
    .res_o   (dv_res)
  );

  logic [dofu_pkg::OPA_BITS-1:0] opa;

  always_comb begin
    case (dv_res.sel)
      dofu_pkg::SEL_ZERO: opa = '0;
      dofu_pkg::SEL_NEAR: opa = dv_res.quot;
      dofu_pkg::SEL_FAR:  opa = dofu_pkg::ONE - dv_res.quot;
      default:            opa = dofu_pkg::ONE;
    endcase
  end

  // Output word plus one skid word.
  logic pop;
  assign pop = out_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (dv_v) begin
      out_v_q  <= 1'b1;
      skid_v_q <= out_v_q && !out_o.ready;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_d_q <= skid_d_q;
      end
    end else if (dv_v) begin
      if (!out_v_q || out_o.ready) begin
        out_d_q <= opa;
      end else begin
        skid_d_q <= opa;
      end
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.opacity = out_d_q;

  `ASSERT_STD(a_skid_needs_out, skid_v_q |-> out_v_q, "skid word held without output word")
  `ASSERT_STD(a_word_lands, (en && dv_v) |=> out_v_q, "pipeline word dropped at output")
  `ASSERT_STD(a_opa_range, out_v_q |-> (out_d_q <= dofu_pkg::ONE), "opacity above one")

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import dofu_pkg::*;

  localparam int LATENCY = 47;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [DIST_BITS-1:0] cfg_wdata_i = '0;

  dofu_in_if in_if ();
  dofu_out_if out_if ();

  distance_opacity_fade_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  typedef struct {
    logic signed [COORD_BITS-1:0] tx, ty, tz, rx, ry, rz;
  } point_pair_t;

  logic [DIST_BITS-1:0] near_transp_q, near_opaque_q, far_opaque_q, far_transp_q;
  logic [OPA_BITS-1:0] opacity_queue[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  bit hold_off = 1'b0;
  int unsigned gap_max = 4;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.target_x = '0;
    in_if.target_y = '0;
    in_if.target_z = '0;
    in_if.ref_x = '0;
    in_if.ref_y = '0;
    in_if.ref_z = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] ramp_frac(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return 64'(ONE);
    q = (num << OPA_FRAC_BITS) / den;
    return (q > 64'(ONE)) ? 64'(ONE) : q;
  endfunction

  function automatic logic [63:0] axis_gap(logic signed [COORD_BITS-1:0] a,
                                           logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [OPA_BITS-1:0] fade_opacity(point_pair_t p);
    logic [63:0] dx, dy, dz, d, op;
    dx = axis_gap(p.tx, p.rx);
    dy = axis_gap(p.ty, p.ry);
    dz = axis_gap(p.tz, p.rz);
    d = floor_sqrt(dx * dx + dy * dy + dz * dz);
    if (d > far_transp_q || d < near_transp_q) op = 0;
    else if (d > far_opaque_q)
      op = 64'(ONE) - ramp_frac(d - far_opaque_q, far_transp_q - far_opaque_q);
    else if (d < near_opaque_q)
      op = ramp_frac(d - near_transp_q, near_opaque_q - near_transp_q);
    else op = 64'(ONE);
    return op[OPA_BITS-1:0];
  endfunction

  task automatic send_word(point_pair_t p);
    in_if.valid <= 1'b1;
    in_if.target_x <= p.tx;
    in_if.target_y <= p.ty;
    in_if.target_z <= p.tz;
    in_if.ref_x <= p.rx;
    in_if.ref_y <= p.ry;
    in_if.ref_z <= p.rz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    opacity_queue.push_back(fade_opacity(p));
    words_sent++;
  endtask

  // Bursts of back-to-back words separated by random gaps.
  task automatic send_stream(point_pair_t p);
    send_word(p);
    if (gap_max != 0 && $urandom_range(5, 0) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (opacity_queue.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DIST_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_NEAR_TRANSP: near_transp_q = val;
      REG_NEAR_OPAQUE: near_opaque_q = val;
      REG_FAR_OPAQUE:  far_opaque_q = val;
      default:         far_transp_q = val;
    endcase
  endtask

  task automatic set_fade(logic [DIST_BITS-1:0] nt, no, fo, ft);
    write_reg(REG_NEAR_TRANSP, nt);
    write_reg(REG_NEAR_OPAQUE, no);
    write_reg(REG_FAR_OPAQUE, fo);
    write_reg(REG_FAR_TRANSP, ft);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(3, 0))
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'($signed($urandom_range(8000, 0)) - 4000);
      2: return $urandom_range(1, 0) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                      : {1'b0, {(COORD_BITS-1){1'b1}}};
      default: return COORD_BITS'($signed($urandom_range(600000, 0)) - 300000);
    endcase
  endfunction

  // Mostly offset the target from the reference along a random axis mix, else pick both at random.
  function automatic point_pair_t rand_pair();
    point_pair_t p;
    p.rx = rand_coord();
    p.ry = rand_coord();
    p.rz = rand_coord();
    if ($urandom_range(3, 0) != 0) begin
      p.tx = p.rx + COORD_BITS'($signed($urandom_range(200000, 0)) - 100000);
      p.ty = p.ry + COORD_BITS'($signed($urandom_range(2000, 0)) - 1000);
      p.tz = p.rz + COORD_BITS'($signed($urandom_range(200000, 0)) - 100000);
    end else begin
      p.tx = rand_coord();
      p.ty = rand_coord();
      p.tz = rand_coord();
    end
    return p;
  endfunction

  function automatic point_pair_t on_axis(int signed ox, int signed oy, int signed oz);
    point_pair_t p;
    p.rx = '0; p.ry = '0; p.rz = '0;
    p.tx = COORD_BITS'(ox); p.ty = COORD_BITS'(oy); p.tz = COORD_BITS'(oz);
    return p;
  endfunction

  task automatic test_reset_defaults();
    set_fade('0, '0, '0, '0);
    send_stream(on_axis(0, 0, 0));
    send_stream(on_axis(1, 0, 0));
    stop_sending();
    drain();
  endtask

  task automatic test_directed_trapezoid();
    point_pair_t p;
    int signed dists[12];
    dists = '{0, 255, 256, 500, 1000, 1999, 2000, 3000, 4000, 4500, 5000, 5001};
    set_fade(24'd256, 24'd1000, 24'd4000, 24'd5000);
    foreach (dists[i]) send_stream(on_axis(dists[i], 0, 0));
    send_stream(on_axis(0, -3000, 0));
    send_stream(on_axis(300, 400, 1200));
    // Extreme corners: largest possible distance.
    p.tx = {1'b1, {(COORD_BITS-1){1'b0}}}; p.ty = p.tx; p.tz = p.tx;
    p.rx = {1'b0, {(COORD_BITS-1){1'b1}}}; p.ry = p.rx; p.rz = p.rx;
    send_stream(p);
    p.tx = p.rx; p.ty = p.rx; p.tz = p.rx;
    send_stream(p);
    stop_sending();
    drain();
  endtask

  task automatic test_extreme_and_unordered();
    // Widest window, then unordered and degenerate distances.
    set_fade('0, 24'd1, '1, '1);
    send_stream(on_axis(0, 0, 0));
    send_stream(on_axis(-8388608, 8388607, -8388608));
    stop_sending();
    drain();
    set_fade(24'd5000, 24'd100, 24'd3000, 24'd200);
    for (int i = 0; i < 8; i++) send_stream(on_axis(i * 800, 0, 0));
    stop_sending();
    drain();
    set_fade(24'd1000, 24'd1000, 24'd1000, 24'd1000);
    send_stream(on_axis(999, 0, 0));
    send_stream(on_axis(1000, 0, 0));
    send_stream(on_axis(1001, 0, 0));
    stop_sending();
    drain();
  endtask

  task automatic test_random_streams();
    logic [DIST_BITS-1:0] a[4];
    logic [DIST_BITS-1:0] t;
    for (int phase = 0; phase < 7; phase++) begin
      foreach (a[i]) a[i] = (phase % 2) ? DIST_BITS'($urandom)
                                        : DIST_BITS'($urandom_range(40000, 0));
      // Mostly ordered thresholds; sort them.
      if (phase != 6) begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 3 - i; j++)
            if (a[j] > a[j+1]) begin
              t = a[j]; a[j] = a[j+1]; a[j+1] = t;
            end
      end
      set_fade(a[0], a[1], a[2], a[3]);
      gap_max = (phase == 3) ? 0 : 6;
      for (int n = 0; n < 95; n++) send_stream(rand_pair());
      stop_sending();
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_fade(24'd0, 24'd20000, 24'd60000, 24'd90000);
    gap_max = 0;
    hold_off = 1'b1;
    for (int n = 0; n < 80; n++) send_stream(rand_pair());
    stop_sending();
    drain();
  endtask

  // Receiver: a stall pattern of its own, plus one long hold-off.
  initial begin
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      case ($urandom_range(7, 0))
        0, 1:    out_if.ready <= 1'b0;
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Compare each result word with the oldest expected opacity.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (opacity_queue.size() == 0) begin
        $error("opacity: result word with none expected, actual %0d", out_if.opacity);
        errors++;
      end else begin
        if (out_if.opacity !== opacity_queue[0]) begin
          $error("opacity: expected %0d, actual %0d", opacity_queue[0], out_if.opacity);
          errors++;
        end
        void'(opacity_queue.pop_front());
      end
      words_checked++;
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_trapezoid();
    test_extreme_and_unordered();
    test_random_streams();
    test_backpressure();
    if (opacity_queue.size() != 0) begin
      $error("opacity: %0d expected words never arrived", opacity_queue.size());
      errors++;
    end
    $display("Covered %0d words over ordered, unordered and extreme fade windows,",
             words_sent);
    $display("with input gaps, output stalls and a long hold-off; %0d results checked.",
             words_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
